@@ rtl/ibss_pkg.sv @@
// ----------------------------------------------------------------------------
// ibss_pkg: shared types and constants for the indexed byte sequence store
// Opcodes, status codes, cell commands and the per-cycle cell command struct.
// ----------------------------------------------------------------------------
package ibss_pkg;

  localparam int DEPTH = 32;                       // number of element cells
  localparam int OP_W  = 3;                        // opcode width
  localparam int POS_W = 6;                        // position port width
  localparam int SYM_W = 8;                        // element width
  localparam int STAT_W = 2;                       // status width
  localparam int LEN_W = 6;                        // length port width
  localparam int CNT_W = $clog2(DEPTH + 1);        // holds 0..DEPTH
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND       = 3'd0,
    OP_INSERT       = 3'd1,
    OP_REMOVE       = 3'd2,
    OP_REMOVE_FIRST = 3'd3,
    OP_REMOVE_LAST  = 3'd4,
    OP_DUMP         = 3'd5
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    MODE_IDLE,
    MODE_DUMP
  } mode_t;

  // Broadcast to every cell each cycle
  typedef struct packed {
    cell_op_t                 op;
    logic [CMP_W-1:0]         pos;
    logic [CMP_W-1:0]         count;
    logic signed [SYM_W-1:0]  symbol;
  } cell_cmd_t;

endpackage

@@ rtl/indexed_byte_sequence_store_top.sv @@
// ----------------------------------------------------------------------------
// indexed_byte_sequence_store_top: ordered store of up to DEPTH signed bytes
// The first result of every request is registered and appears in the cycle after it is taken.
// Append, insert and the removes never raise busy, so they can follow back to back.
// A dump gives one result per cycle, one per stored element (one when empty),
// holding busy for all but its first cycle while the row rotates to its head.
// Reset (rst, synchronous): mode idle, count to zero, strobe low; element cells uncleared.
// ----------------------------------------------------------------------------
module indexed_byte_sequence_store_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [ibss_pkg::OP_W-1:0]           opcode,
  input  logic [ibss_pkg::POS_W-1:0]          position,
  input  logic signed [ibss_pkg::SYM_W-1:0]   symbol,
  output logic                                strobe,
  output logic [ibss_pkg::STAT_W-1:0]         status,
  output logic signed [ibss_pkg::SYM_W-1:0]   element,
  output logic                                element_valid,
  output logic                                last,
  output logic [ibss_pkg::LEN_W-1:0]          length
);

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  ibss_pkg::mode_t            mode, mode_next;
  logic [ibss_pkg::CNT_W-1:0] count, count_next;
  logic [ibss_pkg::CNT_W-1:0] dump_left, dump_left_next;

  // Result registers (strobe is control, the rest is payload)
  logic                              strobe_next;
  logic [ibss_pkg::STAT_W-1:0]       status_next;
  logic signed [ibss_pkg::SYM_W-1:0] element_next;
  logic                              element_valid_next;
  logic                              last_next;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic                       req;
  logic [ibss_pkg::CMP_W-1:0] cnt_ext;
  logic [ibss_pkg::CMP_W-1:0] pos_ext;
  logic [ibss_pkg::CMP_W-1:0] pos_eff;
  logic                       is_insert;
  logic                       is_remove;
  logic                       is_dump;
  logic                       full;
  logic                       empty;
  ibss_pkg::status_t          req_status;
  ibss_pkg::cell_cmd_t        cmd;

  logic signed [ibss_pkg::SYM_W-1:0] cell_data [ibss_pkg::DEPTH];

  assign busy    = (mode == ibss_pkg::MODE_DUMP);
  assign req     = start && !busy;
  assign cnt_ext = ibss_pkg::CMP_W'(count);
  assign pos_ext = ibss_pkg::CMP_W'(position);
  assign full    = (count == ibss_pkg::CNT_W'(ibss_pkg::DEPTH));
  assign empty   = (count == '0);

  always_comb begin
    is_insert = 1'b0;
    is_remove = 1'b0;
    is_dump   = 1'b0;
    pos_eff   = pos_ext;
    case (opcode)
      ibss_pkg::OP_APPEND: begin
        is_insert = 1'b1;
        pos_eff   = cnt_ext;
      end
      ibss_pkg::OP_INSERT: begin
        is_insert = 1'b1;
      end
      ibss_pkg::OP_REMOVE: begin
        is_remove = 1'b1;
      end
      ibss_pkg::OP_REMOVE_FIRST: begin
        is_remove = 1'b1;
        pos_eff   = '0;
      end
      ibss_pkg::OP_REMOVE_LAST: begin
        is_remove = 1'b1;
        pos_eff   = cnt_ext - ibss_pkg::CMP_W'(1);   // unused when empty
      end
      ibss_pkg::OP_DUMP: begin
        is_dump = 1'b1;
      end
      default: begin
        pos_eff = pos_ext;                          // unknown: refused below
      end
    endcase
  end

  // Status of a request; a dump always reports done
  always_comb begin
    req_status = ibss_pkg::STAT_REFUSED;
    if (is_insert) begin
      // insert at the count is an append; above it is out of range
      if (!full && (pos_eff <= cnt_ext)) begin
        req_status = ibss_pkg::STAT_DONE;
      end
    end else if (is_remove) begin
      if (empty) begin
        req_status = ibss_pkg::STAT_EMPTY;
      end else if (pos_eff < cnt_ext) begin
        req_status = ibss_pkg::STAT_DONE;
      end
    end else if (is_dump) begin
      req_status = ibss_pkg::STAT_DONE;
    end
  end

  // --------------------------------------------------------------------------
  // Cell row command: one shift step per cycle
  // --------------------------------------------------------------------------
  always_comb begin
    cmd.op     = ibss_pkg::CELL_HOLD;
    cmd.pos    = pos_eff;
    cmd.count  = cnt_ext;
    cmd.symbol = symbol;
    if (busy) begin
      cmd.op = ibss_pkg::CELL_ROTATE;
    end else if (req && is_dump && !empty) begin
      // head goes out now; the row starts rotating in the same cycle
      cmd.op = ibss_pkg::CELL_ROTATE;
    end else if (req && (req_status == ibss_pkg::STAT_DONE)) begin
      if (is_insert) begin
        cmd.op = ibss_pkg::CELL_INSERT;
      end else if (is_remove) begin
        cmd.op = ibss_pkg::CELL_REMOVE;
      end
    end
  end

  for (genvar i = 0; i < ibss_pkg::DEPTH; i++) begin : g_cell
    logic signed [ibss_pkg::SYM_W-1:0] left_in;
    logic signed [ibss_pkg::SYM_W-1:0] right_in;

    if (i == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end

    if (i == ibss_pkg::DEPTH - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    ibss_cell u_cell (
      .clk        (clk),
      .idx        (ibss_pkg::CMP_W'(i)),
      .cmd        (cmd),
      .left_data  (left_in),
      .right_data (right_in),
      .head_data  (cell_data[0]),
      .data       (cell_data[i])
    );
  end

  // --------------------------------------------------------------------------
  // Mode: next state
  // --------------------------------------------------------------------------
  always_comb begin
    mode_next = mode;
    case (mode)
      ibss_pkg::MODE_IDLE: begin
        // a single-element dump is finished in the request cycle
        if (req && is_dump && (count > ibss_pkg::CNT_W'(1))) begin
          mode_next = ibss_pkg::MODE_DUMP;
        end
      end
      ibss_pkg::MODE_DUMP: begin
        if (dump_left == ibss_pkg::CNT_W'(1)) begin
          mode_next = ibss_pkg::MODE_IDLE;
        end
      end
      default: begin
        mode_next = ibss_pkg::MODE_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Mode: outputs, count and result
  // --------------------------------------------------------------------------
  always_comb begin
    count_next         = count;
    dump_left_next     = dump_left;
    strobe_next        = 1'b0;
    status_next        = ibss_pkg::STAT_DONE;
    element_next       = '0;
    element_valid_next = 1'b0;
    last_next          = 1'b1;
    case (mode)
      ibss_pkg::MODE_IDLE: begin
        if (req) begin
          strobe_next    = 1'b1;
          status_next    = req_status;
          dump_left_next = count - ibss_pkg::CNT_W'(1);   // elements still to emit
          if (req_status == ibss_pkg::STAT_DONE) begin
            if (is_insert) begin
              count_next = count + ibss_pkg::CNT_W'(1);
            end else if (is_remove) begin
              count_next = count - ibss_pkg::CNT_W'(1);
            end
          end
          // a dump of a non-empty store emits its head element right away
          if (is_dump && !empty) begin
            element_next       = cell_data[0];
            element_valid_next = 1'b1;
            last_next          = (count == ibss_pkg::CNT_W'(1));
          end
        end
      end
      ibss_pkg::MODE_DUMP: begin
        // head cell carries the next element in order
        strobe_next        = 1'b1;
        element_next       = cell_data[0];
        element_valid_next = 1'b1;
        last_next          = (dump_left == ibss_pkg::CNT_W'(1));
        dump_left_next     = dump_left - ibss_pkg::CNT_W'(1);
      end
      default: begin
        strobe_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= ibss_pkg::MODE_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      mode   <= mode_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    dump_left     <= dump_left_next;
    status        <= status_next;
    element       <= element_next;
    element_valid <= element_valid_next;
    last          <= last_next;
    length        <= ibss_pkg::LEN_W'(count_next);
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // every accepted request yields a result in the next cycle
  a_req_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> strobe)
    else $error("request without result");

  // dump results run without gaps until the marked last one
  a_dump_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> (strobe && element_valid))
    else $error("dump result sequence broken");

  // element values only come with a completed dump
  a_elem_done: assert property (@(posedge clk) disable iff (rst)
    (strobe && element_valid) |-> (status == ibss_pkg::STAT_DONE))
    else $error("element emitted with failing status");

  // the count never exceeds the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= ibss_pkg::CNT_W'(ibss_pkg::DEPTH))
    else $error("element count above capacity");
`endif

endmodule

@@ rtl/ibss_cell.sv @@
// ----------------------------------------------------------------------------
// ibss_cell: one element slot of the shifting row
// Holds one byte; takes its left or right neighbor, the new symbol, or the
// head of the row, as the broadcast command and its own index dictate.
// ----------------------------------------------------------------------------
module ibss_cell (
  input  logic                                 clk,
  input  logic [ibss_pkg::CMP_W-1:0]           idx,
  input  ibss_pkg::cell_cmd_t                  cmd,
  input  logic signed [ibss_pkg::SYM_W-1:0]    left_data,
  input  logic signed [ibss_pkg::SYM_W-1:0]    right_data,
  input  logic signed [ibss_pkg::SYM_W-1:0]    head_data,
  output logic signed [ibss_pkg::SYM_W-1:0]    data
);

  logic signed [ibss_pkg::SYM_W-1:0] data_next;
  logic [ibss_pkg::CMP_W-1:0]        idx_plus1;

  assign idx_plus1 = idx + ibss_pkg::CMP_W'(1);

  always_comb begin
    data_next = data;
    case (cmd.op)
      ibss_pkg::CELL_INSERT: begin
        if (idx > cmd.pos) begin
          data_next = left_data;
        end else if (idx == cmd.pos) begin
          data_next = cmd.symbol;
        end
      end
      ibss_pkg::CELL_REMOVE: begin
        if (idx >= cmd.pos) begin
          data_next = right_data;
        end
      end
      ibss_pkg::CELL_ROTATE: begin
        // rotate the occupied part left; the head wraps to the tail
        if (idx_plus1 < cmd.count) begin
          data_next = right_data;
        end else if (idx_plus1 == cmd.count) begin
          data_next = head_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for indexed_byte_sequence_store_top
// Sends append, insert, remove and dump requests over the start/busy
// handshake, tracks the stored sequence in a queue of its own and checks
// every strobed result, field by field, against the oldest expected one.
// ----------------------------------------------------------------------------
module tb;

  // Opcodes the block does not define; both must be refused
  localparam logic [ibss_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [ibss_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam int MAX_POS     = (1 << ibss_pkg::POS_W) - 1;
  localparam int MAX_IDLE    = 11;                        // longest sender gap, cycles
  localparam int DRAIN_LIMIT = 8 * ibss_pkg::DEPTH + 64;  // cycles allowed for the tail
  localparam int TIMEOUT     = 4000000;                   // watchdog limit, in simulation time units

  // One expected result, as the block should present it on its ports
  typedef struct {
    ibss_pkg::status_t                 status;
    logic signed [ibss_pkg::SYM_W-1:0] element;
    logic                              element_valid;
    logic                              last;
    logic [ibss_pkg::LEN_W-1:0]        length;
  } seq_result_t;

  // DUT ports; every input has a known value from time zero
  logic                              clk;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic [ibss_pkg::OP_W-1:0]         opcode = ibss_pkg::OP_APPEND;
  logic [ibss_pkg::POS_W-1:0]        position = '0;
  logic signed [ibss_pkg::SYM_W-1:0] symbol = '0;
  logic                              strobe;
  logic [ibss_pkg::STAT_W-1:0]       status;
  logic signed [ibss_pkg::SYM_W-1:0] element;
  logic                              element_valid;
  logic                              last;
  logic [ibss_pkg::LEN_W-1:0]        length;

  // Bench-side copy of the stored sequence, head at index 0
  logic signed [ibss_pkg::SYM_W-1:0] stored_seq [$];
  // Results owed by the block, oldest first
  seq_result_t                       owed_results [$];
  int                                error_count = 0;

  indexed_byte_sequence_store_top u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .position      (position),
    .symbol        (symbol),
    .strobe        (strobe),
    .status        (status),
    .element       (element),
    .element_valid (element_valid),
    .last          (last),
    .length        (length)
  );

  // 20-unit clock, first rising edge at 10
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Sequence tracking
  // ---------------------------------------------------------------------------

  // Length is taken after the operation has been applied
  function automatic void owe_result(ibss_pkg::status_t st,
                                     logic signed [ibss_pkg::SYM_W-1:0] el,
                                     logic el_valid, logic is_last);
    seq_result_t r;
    r.status        = st;
    r.element       = el;
    r.element_valid = el_valid;
    r.last          = is_last;
    r.length        = ibss_pkg::LEN_W'(stored_seq.size());
    owed_results.push_back(r);
  endfunction

  // Full store or a position past the end is refused; position == count appends
  function automatic ibss_pkg::status_t seq_insert(int pos,
                                                   logic signed [ibss_pkg::SYM_W-1:0] sym);
    if (stored_seq.size() >= ibss_pkg::DEPTH || pos > stored_seq.size())
      return ibss_pkg::STAT_REFUSED;
    stored_seq.insert(pos, sym);
    return ibss_pkg::STAT_DONE;
  endfunction

  // Empty store reports nothing to remove before the range check
  function automatic ibss_pkg::status_t seq_remove(int pos);
    if (stored_seq.size() == 0)
      return ibss_pkg::STAT_EMPTY;
    if (pos >= stored_seq.size())
      return ibss_pkg::STAT_REFUSED;
    stored_seq.delete(pos);
    return ibss_pkg::STAT_DONE;
  endfunction

  // Applies one accepted request to the tracked sequence, queues its results
  function automatic void apply_request(logic [ibss_pkg::OP_W-1:0] op,
                                        logic [ibss_pkg::POS_W-1:0] pos,
                                        logic signed [ibss_pkg::SYM_W-1:0] sym);
    ibss_pkg::status_t st;
    int                n;
    n = stored_seq.size();
    if (op == ibss_pkg::OP_DUMP) begin
      // Empty dump still gives one closing result with no element
      if (n == 0)
        owe_result(ibss_pkg::STAT_DONE, '0, 1'b0, 1'b1);
      for (int i = 0; i < n; i++)
        owe_result(ibss_pkg::STAT_DONE, stored_seq[i], 1'b1, i == n - 1);
    end else begin
      case (op)
        ibss_pkg::OP_APPEND:       st = seq_insert(n, sym);
        ibss_pkg::OP_INSERT:       st = seq_insert(int'(pos), sym);
        ibss_pkg::OP_REMOVE:       st = seq_remove(int'(pos));
        ibss_pkg::OP_REMOVE_FIRST: st = seq_remove(0);
        ibss_pkg::OP_REMOVE_LAST:  st = (n == 0) ? ibss_pkg::STAT_EMPTY : seq_remove(n - 1);
        default:                   st = ibss_pkg::STAT_REFUSED;
      endcase
      owe_result(st, '0, 1'b0, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    seq_result_t exp_r;
    if (!rst && strobe !== 1'b0) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result: status %0d element %0d valid %0b last %0b length %0d",
               status, element, element_valid, last, length);
        error_count++;
      end else begin
        exp_r = owed_results.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          error_count++;
        end
        if (element !== exp_r.element) begin
          $error("element: expected %0d, got %0d", exp_r.element, element);
          error_count++;
        end
        if (element_valid !== exp_r.element_valid) begin
          $error("element_valid: expected %0b, got %0b", exp_r.element_valid,
                 element_valid);
          error_count++;
        end
        if (last !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, last);
          error_count++;
        end
        if (length !== exp_r.length) begin
          $error("length: expected %0d, got %0d", exp_r.length, length);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Called at a rising edge. Holds the request until an edge sees busy low,
  // then optionally drops start for a random gap. When no gap is taken start
  // stays high, so the next request follows back to back.
  task automatic send_request(input logic [ibss_pkg::OP_W-1:0] op,
                              input logic [ibss_pkg::POS_W-1:0] pos,
                              input logic signed [ibss_pkg::SYM_W-1:0] sym,
                              input bit may_idle);
    int gap;
    start    <= 1'b1;
    opcode   <= op;
    position <= pos;
    symbol   <= sym;
    do @(posedge clk); while (busy !== 1'b0);
    apply_request(op, pos, sym);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, MAX_IDLE);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender holds off until the block has delivered everything it owes.
  // Queue is sampled at the falling edge, clear of the checker's update.
  task automatic wait_for_results();
    start <= 1'b0;
    @(negedge clk);
    while (owed_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // One random request. grow_pct steers the mix between adds and removes so
  // the count sweeps the whole range; most positions are in range.
  task automatic send_random(input int grow_pct, input bit may_idle);
    int                                n;
    int                                r;
    int                                k;
    logic [ibss_pkg::OP_W-1:0]         op;
    logic [ibss_pkg::POS_W-1:0]        pos;
    logic signed [ibss_pkg::SYM_W-1:0] sym;
    n   = stored_seq.size();
    r   = $urandom_range(0, 99);
    sym = ibss_pkg::SYM_W'($urandom());
    if (r < 4)
      op = r[0] ? OP_UNUSED_7 : OP_UNUSED_6;
    else if (r < 12)
      op = ibss_pkg::OP_DUMP;
    else if ($urandom_range(0, 99) < grow_pct)
      op = $urandom_range(0, 1) ? ibss_pkg::OP_INSERT : ibss_pkg::OP_APPEND;
    else begin
      case ($urandom_range(0, 2))
        0:       op = ibss_pkg::OP_REMOVE;
        1:       op = ibss_pkg::OP_REMOVE_FIRST;
        default: op = ibss_pkg::OP_REMOVE_LAST;
      endcase
    end
    k = $urandom_range(0, 9);
    if (k == 0)
      pos = ibss_pkg::POS_W'($urandom_range(0, MAX_POS));   // anything the port allows
    else if (k == 1)
      pos = ibss_pkg::POS_W'($urandom_range(n, MAX_POS));   // at or past the end
    else if (op == ibss_pkg::OP_INSERT)
      pos = ibss_pkg::POS_W'($urandom_range(0, n));
    else
      pos = (n == 0) ? '0 : ibss_pkg::POS_W'($urandom_range(0, n - 1));
    send_request(op, pos, sym, may_idle);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh store: empty dump and every remove flavor on nothing
  task automatic test_empty_store();
    send_request(ibss_pkg::OP_DUMP, '0, '0, 1'b1);
    send_request(ibss_pkg::OP_REMOVE, '0, '0, 1'b1);
    send_request(ibss_pkg::OP_REMOVE_FIRST, '0, '0, 1'b1);
    send_request(ibss_pkg::OP_REMOVE_LAST, '0, '0, 1'b1);
  endtask

  // Byte extremes, head/tail inserts, out-of-range positions, each remove
  task automatic test_edits_and_bounds();
    send_request(ibss_pkg::OP_APPEND, '0, 8'sd127, 1'b1);
    send_request(ibss_pkg::OP_APPEND, '1, -8'sd128, 1'b1);
    send_request(ibss_pkg::OP_INSERT, 6'd0, 8'sd0, 1'b1);        // at the head
    send_request(ibss_pkg::OP_INSERT, 6'd3, -8'sd1, 1'b1);       // position == count
    send_request(ibss_pkg::OP_INSERT, 6'd63, 8'sd5, 1'b1);       // past the end
    send_request(ibss_pkg::OP_INSERT, 6'd5, 8'sd5, 1'b1);        // one past the end
    send_request(ibss_pkg::OP_DUMP, '0, '0, 1'b1);
    send_request(ibss_pkg::OP_REMOVE, 6'd4, '0, 1'b1);           // position == count
    send_request(ibss_pkg::OP_REMOVE, 6'd63, '0, 1'b1);
    send_request(ibss_pkg::OP_REMOVE, 6'd1, '0, 1'b1);           // middle, shifts tail
    send_request(ibss_pkg::OP_REMOVE_FIRST, '0, '0, 1'b1);
    send_request(ibss_pkg::OP_REMOVE_LAST, '0, '0, 1'b1);
    send_request(ibss_pkg::OP_DUMP, '0, '0, 1'b1);               // single element
    send_request(ibss_pkg::OP_REMOVE_LAST, '0, '0, 1'b1);        // back to empty
  endtask

  // Undefined opcodes are refused with the store left alone
  task automatic test_unknown_opcodes();
    send_request(ibss_pkg::OP_APPEND, '0, 8'sd42, 1'b1);
    send_request(OP_UNUSED_6, 6'd0, 8'sd1, 1'b1);
    send_request(OP_UNUSED_7, 6'd0, 8'sd1, 1'b1);
    send_request(ibss_pkg::OP_DUMP, '0, '0, 1'b1);
  endtask

  // Fill to capacity with random content, then push against the limit
  task automatic test_full_store();
    int n;
    while (stored_seq.size() < ibss_pkg::DEPTH) begin
      n = stored_seq.size();
      if ($urandom_range(0, 1))
        send_request(ibss_pkg::OP_APPEND, ibss_pkg::POS_W'($urandom()),
                     ibss_pkg::SYM_W'($urandom()), 1'b1);
      else
        send_request(ibss_pkg::OP_INSERT, ibss_pkg::POS_W'($urandom_range(0, n)),
                     ibss_pkg::SYM_W'($urandom()), 1'b1);
    end
    send_request(ibss_pkg::OP_APPEND, '0, ibss_pkg::SYM_W'($urandom()), 1'b1);
    send_request(ibss_pkg::OP_INSERT, '0, ibss_pkg::SYM_W'($urandom()), 1'b1);
    send_request(ibss_pkg::OP_INSERT, ibss_pkg::POS_W'(ibss_pkg::DEPTH),
                 ibss_pkg::SYM_W'($urandom()), 1'b1);
    send_request(ibss_pkg::OP_DUMP, '0, '0, 1'b1);               // longest dump
    send_request(ibss_pkg::OP_REMOVE, ibss_pkg::POS_W'(ibss_pkg::DEPTH), '0, 1'b1);
    // Hold the sender off once until everything has come back
    wait_for_results();
  endtask

  // Remove everything with random valid positions, then remove from empty
  task automatic test_drain_store();
    int n;
    while (stored_seq.size() > 0) begin
      n = stored_seq.size();
      case ($urandom_range(0, 2))
        0:       send_request(ibss_pkg::OP_REMOVE, ibss_pkg::POS_W'($urandom_range(0, n - 1)),
                              ibss_pkg::SYM_W'($urandom()), 1'b1);
        1:       send_request(ibss_pkg::OP_REMOVE_FIRST, ibss_pkg::POS_W'($urandom()),
                              ibss_pkg::SYM_W'($urandom()), 1'b1);
        default: send_request(ibss_pkg::OP_REMOVE_LAST, ibss_pkg::POS_W'($urandom()),
                              ibss_pkg::SYM_W'($urandom()), 1'b1);
      endcase
    end
    send_request(ibss_pkg::OP_REMOVE, ibss_pkg::POS_W'($urandom()),
                 ibss_pkg::SYM_W'($urandom()), 1'b1);
    send_request(ibss_pkg::OP_REMOVE_LAST, ibss_pkg::POS_W'($urandom()),
                 ibss_pkg::SYM_W'($urandom()), 1'b1);
    send_request(ibss_pkg::OP_DUMP, '0, '0, 1'b1);
  endtask

  // Segments alternate between growing and shrinking, with and without gaps
  task automatic test_random_mix();
    int grow_pct;
    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0:       grow_pct = 80;
        1:       grow_pct = 50;
        2:       grow_pct = 20;
        default: grow_pct = 60;
      endcase
      for (int i = 0; i < 35; i++)
        send_random(grow_pct, seg != 2 && seg != 5);
      if (seg == 3)
        wait_for_results();
    end
  endtask

  // Closing stretch: back-to-back requests, no sender gaps
  task automatic test_back_to_back();
    for (int i = 0; i < 50; i++)
      send_random(55, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    int cycles;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_edits_and_bounds();
    test_unknown_opcodes();
    test_full_store();
    test_drain_store();
    test_random_mix();
    test_back_to_back();

    // Let the block finish what it owes, then watch for stray strobes
    start <= 1'b0;
    cycles = 0;
    @(negedge clk);
    while (owed_results.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      cycles++;
    end
    if (owed_results.size() != 0) begin
      $error("results never delivered: %0d outstanding", owed_results.size());
      error_count++;
    end
    repeat (4) @(posedge clk);

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #(TIMEOUT);
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ibss_pkg.sv
rtl/ibss_cell.sv
rtl/indexed_byte_sequence_store_top.sv
verif/tb.sv
